// ===== rtl/sida_pkg.sv =====
// Shared types and constants for the signed integer to decimal ASCII unit.
package sida_pkg;

  localparam logic [5:0] CHAR_MINUS = 6'd45;
  localparam logic [5:0] CHAR_ZERO  = 6'd48;

  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_DABBLE = 3'd1;
  localparam step_t STEP_SIGN   = 3'd2;
  localparam step_t STEP_SKIP   = 3'd3;
  localparam step_t STEP_EMIT   = 3'd4;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_DABBLE,
    OP_SIGN,
    OP_SKIP,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    C_ALWAYS,
    C_START,
    C_CNT_NZ,
    C_LEAD_ZERO
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jt;
    step_t jf;
  } ctrl_t;

endpackage

// ===== rtl/sida_ucode.sv =====
// Microcode ROM: one control word per sequencer step.
module sida_ucode (
  input  sida_pkg::step_t step,
  output sida_pkg::ctrl_t ctrl
);

  always_comb begin
    unique case (step)
      sida_pkg::STEP_IDLE: begin
        ctrl = '{sida_pkg::OP_LOAD, sida_pkg::C_START,
                 sida_pkg::STEP_DABBLE, sida_pkg::STEP_IDLE};
      end
      sida_pkg::STEP_DABBLE: begin
        ctrl = '{sida_pkg::OP_DABBLE, sida_pkg::C_CNT_NZ,
                 sida_pkg::STEP_DABBLE, sida_pkg::STEP_SIGN};
      end
      sida_pkg::STEP_SIGN: begin
        ctrl = '{sida_pkg::OP_SIGN, sida_pkg::C_ALWAYS,
                 sida_pkg::STEP_SKIP, sida_pkg::STEP_SKIP};
      end
      sida_pkg::STEP_SKIP: begin
        ctrl = '{sida_pkg::OP_SKIP, sida_pkg::C_LEAD_ZERO,
                 sida_pkg::STEP_SKIP, sida_pkg::STEP_EMIT};
      end
      sida_pkg::STEP_EMIT: begin
        ctrl = '{sida_pkg::OP_EMIT, sida_pkg::C_CNT_NZ,
                 sida_pkg::STEP_EMIT, sida_pkg::STEP_IDLE};
      end
      default: begin
        ctrl = '{sida_pkg::OP_LOAD, sida_pkg::C_ALWAYS,
                 sida_pkg::STEP_IDLE, sida_pkg::STEP_IDLE};
      end
    endcase
  end

endmodule

// ===== rtl/signed_int_to_decimal_ascii_unit.sv =====
// Top level: signed integer to decimal ASCII text, microcoded sequencer.
//
//  channel | ports                              | handshake
//  --------+------------------------------------+---------------------------
//  input   | in_value                           | start high, busy low
//  result  | out_character, out_last            | out_valid strobe, 1 cycle
//
// One word takes the same time whatever its value, made up of the accept cycle, one
// double dabble step per magnitude bit, the sign step, one skip step per leading
// zero digit plus one, and one emit step per digit.
// Synchronous active-low reset returns the sequencer to idle with no strobe.
// The receiver cannot stall; digits leave at one per cycle, the last one in the
// cycle in which the next word can be accepted.
module signed_int_to_decimal_ascii_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  output logic [5:0]             out_character,
  output logic                   out_last
);

  localparam int ND    = (VALUE_WIDTH * 3) / 10 + 1;
  localparam int BCD_W = 4 * ND;
  localparam int CW    = $clog2(VALUE_WIDTH);

  sida_pkg::step_t pc_r, pc_nxt;
  sida_pkg::ctrl_t ctrl;

  logic                   neg_r, neg_nxt;
  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [BCD_W-1:0]       bcd_adj;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [5:0]             out_character_r, out_character_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   cnt_nz;
  logic                   lead_zero;
  logic                   take;

  sida_ucode u_ucode (
    .step (pc_r),
    .ctrl (ctrl)
  );

  assign busy      = (pc_r != sida_pkg::STEP_IDLE);
  assign cnt_nz    = (cnt_r != '0);
  assign lead_zero = (bcd_r[BCD_W-1 -: 4] == 4'd0) && cnt_nz;

  // add 3 to every digit of 5 or more before each shift
  always_comb begin
    for (int i = 0; i < ND; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                       : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    neg_nxt           = neg_r;
    mag_nxt           = mag_r;
    bcd_nxt           = bcd_r;
    cnt_nxt           = cnt_r;
    out_valid_nxt     = 1'b0;
    out_character_nxt = out_character_r;
    out_last_nxt      = out_last_r;
    unique case (ctrl.op)
      sida_pkg::OP_LOAD: begin
        if (start) begin
          neg_nxt = in_value[VALUE_WIDTH-1];
          mag_nxt = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;
          bcd_nxt = '0;
          cnt_nxt = CW'(VALUE_WIDTH - 1);
        end
      end
      sida_pkg::OP_DABBLE: begin
        {bcd_nxt, mag_nxt} = {bcd_adj[BCD_W-2:0], mag_r, 1'b0};
        cnt_nxt            = cnt_r - 1'b1;
      end
      sida_pkg::OP_SIGN: begin
        out_valid_nxt     = neg_r;
        out_character_nxt = sida_pkg::CHAR_MINUS;
        out_last_nxt      = 1'b0;
        cnt_nxt           = CW'(ND - 1);
      end
      sida_pkg::OP_SKIP: begin
        if (lead_zero) begin
          bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      sida_pkg::OP_EMIT: begin
        out_valid_nxt     = 1'b1;
        out_character_nxt = sida_pkg::CHAR_ZERO + {2'b00, bcd_r[BCD_W-1 -: 4]};
        out_last_nxt      = !cnt_nz;
        bcd_nxt           = {bcd_r[BCD_W-5:0], 4'd0};
        cnt_nxt           = cnt_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (ctrl.cond)
      sida_pkg::C_ALWAYS:    take = 1'b1;
      sida_pkg::C_START:     take = start;
      sida_pkg::C_CNT_NZ:    take = cnt_nz;
      sida_pkg::C_LEAD_ZERO: take = lead_zero;
      default:               take = 1'b0;
    endcase
    pc_nxt = take ? ctrl.jt : ctrl.jf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= sida_pkg::STEP_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r           <= neg_nxt;
    mag_r           <= mag_nxt;
    bcd_r           <= bcd_nxt;
    cnt_r           <= cnt_nxt;
    out_character_r <= out_character_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(pc_r) == sida_pkg::STEP_SIGN || $past(pc_r) == sida_pkg::STEP_EMIT)
    else $error("strobe outside sign or emit step");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy ##1 !out_valid)
    else $error("characters continue after last");

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_character == sida_pkg::CHAR_MINUS |-> !out_last)
    else $error("minus sign flagged as last");
`endif

endmodule
